/* src/assert_macros.svh */
// Assertion macros for the RTL of the sample player.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

/* src/fsp_pkg.sv */
// Package of the sample player: codes, constants and memory port types.
package fsp_pkg;
   localparam int CHANNELS_DEF = 2;
   localparam int FRAMES_DEF   = 16384;

   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_PLAY  = 3'd1;
   localparam logic [2:0] OP_PAUSE = 3'd2;
   localparam logic [2:0] OP_STOP  = 3'd3;
   localparam logic [2:0] OP_SEEK  = 3'd4;
   localparam logic [2:0] OP_LOAD  = 3'd5;

   localparam logic [1:0] REG_RATE = 2'd0;
   localparam logic [1:0] REG_STEP = 2'd1;
   localparam logic [1:0] REG_LEN  = 2'd2;

   localparam logic [1:0] FADE_NONE = 2'd0;
   localparam logic [1:0] FADE_IN   = 2'd1;
   localparam logic [1:0] FADE_OUT  = 2'd2;

   localparam logic [1:0] PEND_STOP  = 2'd0;
   localparam logic [1:0] PEND_PAUSE = 2'd1;
   localparam logic [1:0] PEND_SEEK  = 2'd2;

   localparam logic [1:0] PS_STOPPED  = 2'd0;
   localparam logic [1:0] PS_PLAYING  = 2'd1;
   localparam logic [1:0] PS_PAUSED   = 2'd2;
   localparam logic [1:0] PS_FINISHED = 2'd3;

   localparam logic signed [23:0] RATE_RESET = 24'sd65536;
   localparam logic [24:0] STEP_RESET = 25'd34953;
   localparam logic [24:0] GAIN_ONE   = 25'd16777216;
   localparam logic signed [22:0] SIXTH_Q24  = 23'sd2796203;
   localparam logic signed [18:0] FRAC_LIMIT = 19'sd131072;

   typedef struct packed {
      logic              en;
      logic [2:0]        chan;
      logic [15:0]       frame;
      logic signed [15:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic [2:0]  chan;
      logic [15:0] frame;
   } mem_rd_type;
endpackage

/* src/fsp_sample_mem.sv */
// Sample store: one write port, one registered read port.
module fsp_sample_mem #(
   parameter int CHANNELS = fsp_pkg::CHANNELS_DEF,
   parameter int FRAMES   = fsp_pkg::FRAMES_DEF
) (
   input  logic               clock,
   input  fsp_pkg::mem_wr_type wr,
   input  fsp_pkg::mem_rd_type rd,
   output logic signed [15:0] rd_data_ff
);
   localparam int DEPTH = CHANNELS * FRAMES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic signed [15:0] mem [DEPTH];
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;

   assign wr_addr = AW'(32'(wr.chan) * FRAMES + 32'(wr.frame));
   assign rd_addr = AW'(32'(rd.chan) * FRAMES + 32'(rd.frame));

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end
endmodule

/* src/faded_sample_player.sv */
// Top level of the faded sample player: command decode, fades, cubic datapath.
//
//  channel | ports             | moves
//  req     | req_valid/ready   | command word: tick, play, pause, stop, seek, load
//  rsp     | rsp_valid/ready   | result word: one per channel on a tick
//  csr     | csr_write_enable  | register write, no wait
//
// Commands other than tick complete while the sequencer stays idle. A reading tick
// passes the fade, advance and status steps, then per channel a setup step, four sample-store
// reads through the single read port, a read-latency step, nine arithmetic steps
// and one output step. A tick that does not read goes from setup straight to output.
// Reset clears control state; the sample store keeps its contents.
// A stalled rsp holds the sequencer in its output step; a new command is taken
// while the last result of a tick still waits.
module faded_sample_player #(
   parameter int CHANNELS = fsp_pkg::CHANNELS_DEF,
   parameter int FRAMES   = fsp_pkg::FRAMES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_opcode,
   input  logic [29:0]        req_seek_position,
   input  logic [2:0]         req_load_channel,
   input  logic [13:0]        req_load_address,
   input  logic signed [15:0] req_load_sample,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_channel,
   output logic signed [15:0] rsp_sample_out,
   output logic               rsp_last_channel,
   output logic [1:0]         rsp_play_state,
   output logic [13:0]        rsp_position_frames,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [24:0]        csr_write_data
);
`include "assert_macros.svh"

   typedef enum logic [16:0] {
      ST_IDLE = 17'h00001,
      ST_FADE = 17'h00002,
      ST_ADV  = 17'h00004,
      ST_STAT = 17'h00008,
      ST_CH   = 17'h00010,
      ST_RD   = 17'h00020,
      ST_RDL  = 17'h00040,
      ST_S1   = 17'h00080,
      ST_S2   = 17'h00100,
      ST_S3   = 17'h00200,
      ST_S4   = 17'h00400,
      ST_S5   = 17'h00800,
      ST_S6   = 17'h01000,
      ST_S7   = 17'h02000,
      ST_S8   = 17'h04000,
      ST_S9   = 17'h08000,
      ST_EMIT = 17'h10000
   } state_type;

   state_type state_ff, state_in;

   logic signed [23:0] rate_ff;
   logic [24:0] step_ff;
   logic [14:0] len_ff;

   logic signed [30:0] phase_ff, phase_in;
   logic [24:0] gain_ff, gain_in;
   logic [1:0]  mode_ff, mode_in;
   logic [1:0]  pend_ff, pend_in;
   logic [29:0] seek_ff, seek_in;
   logic playing_ff, playing_in, paused_ff, paused_in, finished_ff, finished_in;

   logic reading_ff, reading_in;
   logic [24:0] mix_gain_ff, mix_gain_in;
   logic signed [30:0] phase_rd_ff, phase_rd_in;
   logic [1:0]  pstate_ff, pstate_in;
   logic [13:0] pos_ff, pos_in;
   logic [2:0]  ch_ff, ch_in;
   logic [1:0]  k_ff, k_in;
   logic        cap_ff, cap_in;
   logic [15:0] idx_ff, idx_in;
   logic signed [18:0] f_ff, f_in;
   logic signed [15:0] tap_ff [4];
   logic signed [17:0] cmb_ff, cmb_in;
   logic signed [18:0] p_ff, p_in, q_ff, q_in, omf_ff, omf_in;
   logic signed [37:0] pf_ff, pf_in;
   logic signed [36:0] inner_ff, inner_in;
   logic signed [55:0] prod1_ff, prod1_in;
   logic signed [62:0] prod2_ff, prod2_in;
   logic signed [39:0] m_ff, m_in;
   logic signed [58:0] mf_ff, mf_in;
   logic signed [15:0] s_ff, s_in;
   logic signed [41:0] sg_ff, sg_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_channel_ff, rsp_channel_in;
   logic signed [15:0] rsp_sample_ff, rsp_sample_in;
   logic rsp_last_ff, rsp_last_in;
   logic [1:0]  rsp_state_ff, rsp_state_in;
   logic [13:0] rsp_pos_ff, rsp_pos_in;

   fsp_pkg::mem_wr_type mem_wr;
   fsp_pkg::mem_rd_type mem_rd;
   logic signed [15:0] mem_rdata;

   logic [16:0] len_eff;
   logic accept;
   logic [15:0] rd_frame;

   logic [25:0] g_up;
   logic signed [26:0] g_dn;
   logic signed [33:0] ph_sum, ph_lim;
   logic signed [17:0] idx_s, idx_hi;
   logic signed [33:0] f_full;
   logic signed [39:0] t_val;
   logic signed [38:0] t6_val;
   logic signed [43:0] vsum;
   logic signed [27:0] v_full;
   logic signed [41:0] sg_rnd;

   assign len_eff  = (32'(len_ff) > FRAMES) ? 17'(FRAMES) : 17'(len_ff);
   assign accept   = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rd_frame = 16'(idx_ff + 16'(k_ff) - 16'd1);

   assign mem_wr.en    = accept && req_opcode == fsp_pkg::OP_LOAD
                         && 32'(req_load_channel) < CHANNELS
                         && 32'(req_load_address) < FRAMES;
   assign mem_wr.chan  = req_load_channel;
   assign mem_wr.frame = 16'(req_load_address);
   assign mem_wr.data  = req_load_sample;
   assign mem_rd.chan  = ch_ff;
   assign mem_rd.frame = rd_frame;

   fsp_sample_mem #(.CHANNELS(CHANNELS), .FRAMES(FRAMES)) u_mem (
      .clock      (clock),
      .wr         (mem_wr),
      .rd         (mem_rd),
      .rd_data_ff (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= fsp_pkg::RATE_RESET;
         step_ff <= fsp_pkg::STEP_RESET;
         len_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            fsp_pkg::REG_RATE: rate_ff <= csr_write_data[23:0];
            fsp_pkg::REG_STEP: step_ff <= csr_write_data;
            fsp_pkg::REG_LEN:  len_ff  <= csr_write_data[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      gain_in     = gain_ff;
      mode_in     = mode_ff;
      pend_in     = pend_ff;
      seek_in     = seek_ff;
      playing_in  = playing_ff;
      paused_in   = paused_ff;
      finished_in = finished_ff;
      reading_in  = reading_ff;
      mix_gain_in = mix_gain_ff;
      phase_rd_in = phase_rd_ff;
      pstate_in   = pstate_ff;
      pos_in      = pos_ff;
      ch_in       = ch_ff;
      k_in        = k_ff;
      cap_in      = (state_ff == ST_RD);
      idx_in      = idx_ff;
      f_in        = f_ff;
      cmb_in      = cmb_ff;
      p_in        = p_ff;
      q_in        = q_ff;
      omf_in      = omf_ff;
      pf_in       = pf_ff;
      inner_in    = inner_ff;
      prod1_in    = prod1_ff;
      prod2_in    = prod2_ff;
      m_in        = m_ff;
      mf_in       = mf_ff;
      s_in        = s_ff;
      sg_in       = sg_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_channel_in = rsp_channel_ff;
      rsp_sample_in  = rsp_sample_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_state_in   = rsp_state_ff;
      rsp_pos_in     = rsp_pos_ff;

      g_up   = 26'(gain_ff) + 26'(step_ff);
      g_dn   = 27'(gain_ff) - 27'(step_ff);
      ph_sum = 34'(phase_ff) + 34'(rate_ff);
      ph_lim = (34'(signed'({1'b0, len_eff})) - 34'sd2) <<< 16;
      idx_s  = 18'(signed'({1'b0, phase_rd_ff[30:16]}));
      idx_hi = 18'(signed'({1'b0, len_eff})) - 18'sd3;
      if (idx_s < 18'sd1) idx_s = 18'sd1;
      if (idx_s > idx_hi) idx_s = idx_hi;
      f_full = 34'(phase_rd_ff) - (34'(idx_s) <<< 16);
      t_val  = 40'(prod1_ff >>> 16);
      t6_val = 39'(prod2_ff >>> 24);
      vsum   = (44'(tap_ff[1]) <<< 16) + 44'(mf_ff >>> 16) + 44'sd32768;
      v_full = 28'(vsum >>> 16);
      sg_rnd = sg_ff + 42'sd8388608;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  fsp_pkg::OP_TICK: state_in = ST_FADE;
                  fsp_pkg::OP_PLAY: begin
                     if (!(playing_ff && !paused_ff && mode_ff != fsp_pkg::FADE_OUT)) begin
                        playing_in  = 1'b1;
                        paused_in   = 1'b0;
                        finished_in = 1'b0;
                        mode_in     = fsp_pkg::FADE_IN;
                        gain_in     = '0;
                     end
                  end
                  fsp_pkg::OP_PAUSE: begin
                     if (playing_ff && !paused_ff) begin
                        mode_in     = fsp_pkg::FADE_OUT;
                        pend_in     = fsp_pkg::PEND_PAUSE;
                        finished_in = 1'b0;
                     end
                  end
                  fsp_pkg::OP_STOP: begin
                     if (playing_ff || paused_ff) begin
                        mode_in     = fsp_pkg::FADE_OUT;
                        pend_in     = fsp_pkg::PEND_STOP;
                        finished_in = 1'b0;
                     end
                  end
                  fsp_pkg::OP_SEEK: begin
                     if (playing_ff && !paused_ff) begin
                        seek_in = req_seek_position;
                        mode_in = fsp_pkg::FADE_OUT;
                        pend_in = fsp_pkg::PEND_SEEK;
                     end else begin
                        phase_in = 31'(req_seek_position);
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FADE: begin
            state_in    = ST_ADV;
            mix_gain_in = playing_ff ? fsp_pkg::GAIN_ONE : '0;
            case (mode_ff)
               fsp_pkg::FADE_IN: begin
                  if (g_up >= 26'(fsp_pkg::GAIN_ONE)) begin
                     gain_in = fsp_pkg::GAIN_ONE;
                     mode_in = fsp_pkg::FADE_NONE;
                  end else begin
                     gain_in = g_up[24:0];
                  end
                  mix_gain_in = gain_in;
               end
               fsp_pkg::FADE_OUT: begin
                  if (g_dn <= 27'sd0) begin
                     gain_in = '0;
                     mode_in = fsp_pkg::FADE_NONE;
                     case (pend_ff)
                        fsp_pkg::PEND_STOP: begin
                           playing_in = 1'b0;
                           paused_in  = 1'b0;
                           phase_in   = '0;
                        end
                        fsp_pkg::PEND_PAUSE: begin
                           playing_in = 1'b0;
                           paused_in  = 1'b1;
                        end
                        fsp_pkg::PEND_SEEK: begin
                           phase_in   = 31'(seek_ff);
                           playing_in = 1'b1;
                           paused_in  = 1'b0;
                           mode_in    = fsp_pkg::FADE_IN;
                        end
                        default: ;
                     endcase
                  end else begin
                     gain_in = g_dn[24:0];
                  end
                  mix_gain_in = gain_in;
               end
               fsp_pkg::FADE_NONE: ;
               default: mix_gain_in = gain_ff;
            endcase
         end
         ST_ADV: begin
            state_in    = ST_STAT;
            reading_in  = playing_ff || mode_ff == fsp_pkg::FADE_OUT;
            phase_rd_in = phase_ff;
            if (playing_ff || mode_ff == fsp_pkg::FADE_OUT) begin
               if (ph_sum >= ph_lim || ph_sum < 34'sd0) begin
                  playing_in  = 1'b0;
                  paused_in   = 1'b0;
                  finished_in = 1'b1;
                  phase_in    = '0;
               end else begin
                  phase_in = 31'(ph_sum);
               end
            end
         end
         ST_STAT: begin
            state_in = ST_CH;
            ch_in    = '0;
            pos_in   = phase_ff[29:16];
            if (finished_ff)     pstate_in = fsp_pkg::PS_FINISHED;
            else if (playing_ff) pstate_in = fsp_pkg::PS_PLAYING;
            else if (paused_ff)  pstate_in = fsp_pkg::PS_PAUSED;
            else                 pstate_in = fsp_pkg::PS_STOPPED;
         end
         ST_CH: begin
            if (reading_ff && len_eff >= 17'd4) begin
               state_in = ST_RD;
               k_in     = '0;
               idx_in   = 16'(idx_s);
               if (f_full > 34'(fsp_pkg::FRAC_LIMIT))       f_in = fsp_pkg::FRAC_LIMIT;
               else if (f_full < -34'(fsp_pkg::FRAC_LIMIT)) f_in = -fsp_pkg::FRAC_LIMIT;
               else                                         f_in = 19'(f_full);
            end else begin
               state_in = ST_EMIT;
               sg_in    = '0;
            end
         end
         ST_RD: begin
            k_in = 2'(k_ff + 2'd1);
            if (k_ff == 2'd3) state_in = ST_RDL;
         end
         ST_RDL: state_in = ST_S1;
         ST_S1: begin
            state_in = ST_S2;
            cmb_in = 18'(tap_ff[2]) - 18'(tap_ff[1]);
            p_in = 19'(20'(tap_ff[3]) - 20'(tap_ff[0])
                   - 20'sd3 * (20'(tap_ff[2]) - 20'(tap_ff[1])));
            q_in = 19'(20'(tap_ff[3]) + 20'sd2 * 20'(tap_ff[0]) - 20'sd3 * 20'(tap_ff[1]));
         end
         ST_S2: begin
            state_in = ST_S3;
            pf_in  = 38'(p_ff) * 38'(f_ff);
            omf_in = 19'sd65536 - f_ff;
         end
         ST_S3: begin
            state_in = ST_S4;
            inner_in = 37'(pf_ff + (38'(q_ff) <<< 16));
         end
         ST_S4: begin
            state_in = ST_S5;
            prod1_in = 56'(inner_ff) * 56'(omf_ff);
         end
         ST_S5: begin
            state_in = ST_S6;
            prod2_in = 63'(t_val) * 63'(fsp_pkg::SIXTH_Q24);
         end
         ST_S6: begin
            state_in = ST_S7;
            m_in = (40'(cmb_ff) <<< 16) - 40'(t6_val);
         end
         ST_S7: begin
            state_in = ST_S8;
            mf_in = 59'(m_ff) * 59'(f_ff);
         end
         ST_S8: begin
            state_in = ST_S9;
            if (v_full > 28'sd32767)       s_in = 16'sd32767;
            else if (v_full < -28'sd32768) s_in = -16'sd32768;
            else                           s_in = 16'(v_full);
         end
         ST_S9: begin
            state_in = ST_EMIT;
            sg_in = 42'(s_ff) * 42'(signed'({1'b0, mix_gain_ff}));
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_channel_in = ch_ff;
               rsp_sample_in  = sg_rnd[39:24];
               rsp_last_in    = (32'(ch_ff) == CHANNELS - 1);
               rsp_state_in   = pstate_ff;
               rsp_pos_in     = pos_ff;
               if (32'(ch_ff) == CHANNELS - 1) begin
                  state_in = ST_IDLE;
               end else begin
                  ch_in    = 3'(ch_ff + 3'd1);
                  state_in = ST_CH;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         gain_ff      <= '0;
         mode_ff      <= fsp_pkg::FADE_NONE;
         pend_ff      <= fsp_pkg::PEND_STOP;
         seek_ff      <= '0;
         playing_ff   <= 1'b0;
         paused_ff    <= 1'b0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         gain_ff      <= gain_in;
         mode_ff      <= mode_in;
         pend_ff      <= pend_in;
         seek_ff      <= seek_in;
         playing_ff   <= playing_in;
         paused_ff    <= paused_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
         cap_ff       <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      reading_ff  <= reading_in;
      mix_gain_ff <= mix_gain_in;
      phase_rd_ff <= phase_rd_in;
      pstate_ff   <= pstate_in;
      pos_ff      <= pos_in;
      ch_ff       <= ch_in;
      k_ff        <= k_in;
      idx_ff      <= idx_in;
      f_ff        <= f_in;
      cmb_ff      <= cmb_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      omf_ff      <= omf_in;
      pf_ff       <= pf_in;
      inner_ff    <= inner_in;
      prod1_ff    <= prod1_in;
      prod2_ff    <= prod2_in;
      m_ff        <= m_in;
      mf_ff       <= mf_in;
      s_ff        <= s_in;
      sg_ff       <= sg_in;
      rsp_channel_ff <= rsp_channel_in;
      rsp_sample_ff  <= rsp_sample_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_state_ff   <= rsp_state_in;
      rsp_pos_ff     <= rsp_pos_in;
      // read data arrives in the cycle after each address; shift in a, b, c, d
      if (cap_ff) begin
         tap_ff[0] <= tap_ff[1];
         tap_ff[1] <= tap_ff[2];
         tap_ff[2] <= tap_ff[3];
         tap_ff[3] <= mem_rdata;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_channel         = rsp_channel_ff;
   assign rsp_sample_out      = rsp_sample_ff;
   assign rsp_last_channel    = rsp_last_ff;
   assign rsp_play_state      = rsp_state_ff;
   assign rsp_position_frames = rsp_pos_ff;

   `ASSERT_IMPL(a_gain_range, 1'b1, gain_ff <= fsp_pkg::GAIN_ONE, "fade gain above unity")
   `ASSERT_IMPL(a_read_in_data, state_ff == ST_RD, 17'(rd_frame) < len_eff, "read past data")
   `ASSERT_NEXT(a_tick_busy, accept && req_opcode == fsp_pkg::OP_TICK, !req_ready, "tick not held")
   `ASSERT_IMPL(a_last_chan, rsp_valid && rsp_last_channel, 32'(rsp_channel) == CHANNELS - 1, "bad last")
endmodule

/* dv/faded_sample_player_test.sv */
// Self-checking testbench of the faded sample player: fades, cubic reads, commands.
module faded_sample_player_test;
   localparam int NCH        = fsp_pkg::CHANNELS_DEF;
   localparam int NFR        = fsp_pkg::FRAMES_DEF;
   localparam int TICK_SPAN  = 4 + 16 * NCH;
   localparam int DATA_SPAN  = 40;
   localparam logic [1:0] REG_NONE = 2'd3;
   localparam logic [2:0] OP_BAD6 = 3'd6;
   localparam logic [2:0] OP_BAD7 = 3'd7;

   typedef struct {
      logic [2:0]         op;
      logic [29:0]        seek;
      logic [2:0]         chan;
      logic [13:0]        addr;
      logic signed [15:0] smp;
   } cmd_word_type;

   typedef struct {
      logic [2:0]         chan;
      logic signed [15:0] smp;
      logic               last;
      logic [1:0]         state;
      logic [13:0]        pos;
   } out_word_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [2:0] req_opcode = 0;
   logic [29:0] req_seek_position = 0;
   logic [2:0] req_load_channel = 0;
   logic [13:0] req_load_address = 0;
   logic signed [15:0] req_load_sample = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [2:0] rsp_channel;
   logic signed [15:0] rsp_sample_out;
   logic rsp_last_channel;
   logic [1:0] rsp_play_state;
   logic [13:0] rsp_position_frames;
   logic csr_write_enable = 0;
   logic [1:0] csr_index = 0;
   logic [24:0] csr_write_data = 0;

   faded_sample_player dut (.*);

   always #4 clock = ~clock;

   cmd_word_type cmd_queue[$];
   out_word_type expected_words[$];
   int errors = 0;
   int sent_count = 0;
   int taken_count = 0;
   int words_seen = 0;

   // player shadow state
   shortint store_mem[NCH][NFR];
   longint pl_rate = 65536, pl_step = 34953, pl_len = 0;
   longint pl_phase = 0, pl_gain = 0, pl_seek = 0;
   logic [1:0] pl_fade = fsp_pkg::FADE_NONE, pl_pend = fsp_pkg::PEND_STOP;
   bit pl_playing = 0, pl_paused = 0, pl_finished = 0;

   function automatic longint cubic_at(int ch, longint ph, longint len);
      longint idx, f, a, b, c, d, cmb, p, q, inner, t, t6, m, u, v;
      idx = ph >>> 16;
      if (idx < 1) idx = 1;
      if (idx > len - 3) idx = len - 3;
      f = ph - idx * 65536;
      if (f > 131072) f = 131072;
      if (f < -131072) f = -131072;
      a = store_mem[ch][idx - 1];
      b = store_mem[ch][idx];
      c = store_mem[ch][idx + 1];
      d = store_mem[ch][idx + 2];
      cmb = c - b;
      p = d - a - 3 * cmb;
      q = d + 2 * a - 3 * b;
      inner = p * f + q * 65536;
      t = (inner * (65536 - f)) >>> 16;
      t6 = (t * longint'(fsp_pkg::SIXTH_Q24)) >>> 24;
      m = cmb * 65536 - t6;
      u = (m * f) >>> 16;
      v = (b * 65536 + u + 32768) >>> 16;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   task automatic predict_cmd(cmd_word_type cw);
      longint vals[NCH];
      longint gain, len, pos;
      logic [1:0] st;
      out_word_type ow;
      case (cw.op)
         fsp_pkg::OP_PLAY: begin
            if (!(pl_playing && !pl_paused && pl_fade != fsp_pkg::FADE_OUT)) begin
               pl_playing = 1; pl_paused = 0; pl_finished = 0;
               pl_fade = fsp_pkg::FADE_IN; pl_gain = 0;
            end
         end
         fsp_pkg::OP_PAUSE: begin
            if (pl_playing && !pl_paused) begin
               pl_fade = fsp_pkg::FADE_OUT; pl_pend = fsp_pkg::PEND_PAUSE; pl_finished = 0;
            end
         end
         fsp_pkg::OP_STOP: begin
            if (pl_playing || pl_paused) begin
               pl_fade = fsp_pkg::FADE_OUT; pl_pend = fsp_pkg::PEND_STOP; pl_finished = 0;
            end
         end
         fsp_pkg::OP_SEEK: begin
            if (pl_playing && !pl_paused) begin
               pl_seek = cw.seek; pl_fade = fsp_pkg::FADE_OUT; pl_pend = fsp_pkg::PEND_SEEK;
            end else begin
               pl_phase = cw.seek;
            end
         end
         fsp_pkg::OP_LOAD: begin
            if (cw.chan < NCH) store_mem[cw.chan][cw.addr] = cw.smp;
         end
         fsp_pkg::OP_TICK: begin
            if (pl_fade != fsp_pkg::FADE_NONE) begin
               if (pl_fade == fsp_pkg::FADE_IN) begin
                  pl_gain += pl_step;
                  if (pl_gain >= longint'(fsp_pkg::GAIN_ONE)) begin
                     pl_gain = fsp_pkg::GAIN_ONE; pl_fade = fsp_pkg::FADE_NONE;
                  end
               end else if (pl_fade == fsp_pkg::FADE_OUT) begin
                  pl_gain -= pl_step;
                  if (pl_gain <= 0) begin
                     pl_gain = 0; pl_fade = fsp_pkg::FADE_NONE;
                     if (pl_pend == fsp_pkg::PEND_STOP) begin
                        pl_playing = 0; pl_paused = 0; pl_phase = 0;
                     end else if (pl_pend == fsp_pkg::PEND_PAUSE) begin
                        pl_playing = 0; pl_paused = 1;
                     end else if (pl_pend == fsp_pkg::PEND_SEEK) begin
                        pl_phase = pl_seek; pl_playing = 1; pl_paused = 0;
                        pl_fade = fsp_pkg::FADE_IN; pl_gain = 0;
                     end
                  end
               end
               gain = pl_gain;
            end else begin
               gain = pl_playing ? longint'(fsp_pkg::GAIN_ONE) : 0;
            end
            len = (pl_len > NFR) ? NFR : pl_len;
            if (pl_playing || pl_fade == fsp_pkg::FADE_OUT) begin
               for (int i = 0; i < NCH; i++)
                  vals[i] = (((len >= 4) ? cubic_at(i, pl_phase, len) : 0) * gain
                             + (1 << 23)) >>> 24;
               pl_phase += pl_rate;
               if (pl_phase >= (len - 2) * 65536 || pl_phase < 0) begin
                  pl_playing = 0; pl_paused = 0; pl_finished = 1; pl_phase = 0;
               end
            end else begin
               foreach (vals[i]) vals[i] = 0;
            end
            st = pl_finished ? fsp_pkg::PS_FINISHED : pl_playing ? fsp_pkg::PS_PLAYING :
                 pl_paused ? fsp_pkg::PS_PAUSED : fsp_pkg::PS_STOPPED;
            pos = pl_phase >>> 16;
            if (pos < 0) pos = 0;
            if (pos > 16383) pos = 16383;
            for (int i = 0; i < NCH; i++) begin
               ow.chan = 3'(i);
               ow.smp = vals[i][15:0];
               ow.last = (i == NCH - 1);
               ow.state = st;
               ow.pos = pos[13:0];
               expected_words.insert(expected_words.size(), ow);
            end
         end
         default: ;
      endcase
   endtask

   // driver: bursts with gaps
   int burst_left = 4, gap_left = 0;
   always @(negedge clock) begin
      if (!(req_valid && sent_count != taken_count)) begin
         if (gap_left > 0 || cmd_queue.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_valid <= 0;
         end else begin
            req_valid <= 1;
            req_opcode <= cmd_queue[0].op;
            req_seek_position <= cmd_queue[0].seek;
            req_load_channel <= cmd_queue[0].chan;
            req_load_address <= cmd_queue[0].addr;
            req_load_sample <= cmd_queue[0].smp;
            sent_count++;
            if (--burst_left <= 0) begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         predict_cmd(cmd_queue.pop_front());
         taken_count++;
      end
   end

   // receiver: windows of stall patterns, one long hold-off
   int hold_left = 0, win_left = 0, win_mode = 0;
   bit hold_used = 0;
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 0;
      end else if (!hold_used && words_seen >= 100) begin
         hold_used = 1;
         hold_left = 400;
         rsp_ready <= 0;
      end else begin
         if (win_left == 0) begin
            win_mode = $urandom_range(2);
            win_left = $urandom_range(20, 120);
         end
         win_left--;
         case (win_mode)
            0: rsp_ready <= 1;
            1: rsp_ready <= ($urandom_range(1) == 1);
            default: rsp_ready <= ($urandom_range(3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      out_word_type ow;
      if (!reset && rsp_valid && rsp_ready) begin
         words_seen++;
         if (expected_words.size() == 0) begin
            $error("unexpected result word, channel %0d", rsp_channel);
            errors++;
         end else begin
            ow = expected_words.pop_front();
            if (rsp_channel !== ow.chan) begin
               $error("channel expected %0d got %0d", ow.chan, rsp_channel); errors++;
            end
            if (rsp_sample_out !== ow.smp) begin
               $error("sample_out expected %0d got %0d", ow.smp, rsp_sample_out); errors++;
            end
            if (rsp_last_channel !== ow.last) begin
               $error("last_channel expected %0d got %0d", ow.last, rsp_last_channel);
               errors++;
            end
            if (rsp_play_state !== ow.state) begin
               $error("play_state expected %0d got %0d", ow.state, rsp_play_state); errors++;
            end
            if (rsp_position_frames !== ow.pos) begin
               $error("position_frames expected %0d got %0d", ow.pos, rsp_position_frames);
               errors++;
            end
         end
      end
   end

   task automatic push_cmd(logic [2:0] op, logic [29:0] seek = 0, logic [2:0] ch = 0,
                           logic [13:0] addr = 0, logic signed [15:0] smp = 0);
      cmd_word_type cw;
      cw.op = op; cw.seek = seek; cw.chan = ch; cw.addr = addr; cw.smp = smp;
      cmd_queue.insert(cmd_queue.size(), cw);
   endtask

   task automatic push_ticks(int n);
      repeat (n) push_cmd(fsp_pkg::OP_TICK, 30'($urandom), 3'($urandom), 14'($urandom),
                          16'($urandom));
   endtask

   task automatic wait_idle();
      while (cmd_queue.size() != 0 || expected_words.size() != 0) @(posedge clock);
      repeat (TICK_SPAN + 20) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [24:0] data);
      @(negedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         fsp_pkg::REG_RATE: pl_rate = longint'($signed(data[23:0]));
         fsp_pkg::REG_STEP: pl_step = data;
         fsp_pkg::REG_LEN:  pl_len = data[14:0];
         default: ;
      endcase
   endtask

   task automatic set_regs(logic [24:0] rate, logic [24:0] step, logic [24:0] len);
      write_reg(fsp_pkg::REG_RATE, rate);
      write_reg(fsp_pkg::REG_STEP, step);
      write_reg(fsp_pkg::REG_LEN, len);
      @(negedge clock);
      csr_write_enable <= 0;
   endtask

   // return to stopped at phase zero so a large length reads only loaded frames
   task automatic park();
      set_regs(25'd65536, fsp_pkg::GAIN_ONE, 25'(DATA_SPAN));
      push_cmd(fsp_pkg::OP_STOP); push_ticks(2); push_cmd(fsp_pkg::OP_STOP); push_ticks(2);
      push_cmd(fsp_pkg::OP_SEEK, 0);
      wait_idle();
   endtask

   function automatic cmd_word_type random_cmd(int len);
      cmd_word_type cw;
      int r;
      r = $urandom_range(99);
      cw.seek = ($urandom_range(1)) ? 30'($urandom_range(0, (len + 2) * 65536))
                                     : 30'($urandom);
      cw.chan = 3'($urandom);
      cw.addr = 14'($urandom);
      cw.smp = 16'($urandom);
      if (r < 60) cw.op = fsp_pkg::OP_TICK;
      else if (r < 68) cw.op = fsp_pkg::OP_PLAY;
      else if (r < 74) cw.op = fsp_pkg::OP_PAUSE;
      else if (r < 80) cw.op = fsp_pkg::OP_STOP;
      else if (r < 88) cw.op = fsp_pkg::OP_SEEK;
      else if (r < 98) begin
         cw.op = fsp_pkg::OP_LOAD;
         if ($urandom_range(3) != 0) begin
            cw.chan = 3'($urandom_range(NCH - 1));
            cw.addr = 14'($urandom_range(DATA_SPAN - 1));
         end
      end else cw.op = ($urandom_range(1)) ? OP_BAD6 : OP_BAD7;
      return cw;
   endfunction

   initial begin
      logic [24:0] rates[6];
      logic [24:0] steps[7];
      int lens[7];
      rates = '{25'd65536, 25'h800000, 25'h7FFFFF, 25'd32768, 25'h1FF0000, 25'd100000};
      steps = '{25'd1, fsp_pkg::GAIN_ONE, 25'd34953, 25'h1FFFFFF, 25'd0, 25'd3000000,
                25'd600000};
      lens = '{DATA_SPAN, 4, 5, 3, 0, 23, 2};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      write_reg(REG_NONE, 25'h1FFFFFF);
      set_regs(25'd65536, 25'd4194304, 25'(DATA_SPAN));

      for (int a = 0; a < DATA_SPAN; a++)
         for (int ch = 0; ch < NCH; ch++)
            push_cmd(fsp_pkg::OP_LOAD, 0, 3'(ch), 14'(a),
                     (a == 0) ? -16'sd32768 : (a == 1) ? 16'sd32767 : 16'($urandom));
      push_cmd(fsp_pkg::OP_LOAD, 30'h3FFFFFFF, 3'd7, 14'h3FFF, 16'sd1);
      push_cmd(fsp_pkg::OP_LOAD, 0, 3'd1, 14'h3FFF, -16'sd1);

      // directed
      push_ticks(1);
      push_cmd(fsp_pkg::OP_PLAY); push_ticks(6);
      push_cmd(fsp_pkg::OP_PAUSE); push_ticks(5);
      push_cmd(fsp_pkg::OP_PLAY); push_ticks(2);
      push_cmd(fsp_pkg::OP_SEEK, 30'h58000); push_ticks(6);
      push_cmd(fsp_pkg::OP_STOP); push_ticks(5);
      push_cmd(fsp_pkg::OP_SEEK, 30'h3FFFFFFF); push_cmd(fsp_pkg::OP_PLAY); push_ticks(2);
      push_cmd(OP_BAD6); push_cmd(OP_BAD7);
      push_cmd(fsp_pkg::OP_SEEK, 0); push_cmd(fsp_pkg::OP_PLAY); push_ticks(3);
      wait_idle();

      // length sweep, with large lengths kept near the loaded frames
      foreach (lens[k]) begin
         if (k == 1 || k == 4) begin
            park();
            set_regs(25'd65536, fsp_pkg::GAIN_ONE, (k == 1) ? 25'(NFR) : 25'h7FFF);
            push_cmd(fsp_pkg::OP_PLAY); push_ticks(12);
            push_cmd(fsp_pkg::OP_PAUSE); push_ticks(2);
            push_cmd(fsp_pkg::OP_PLAY); push_ticks(4);
            push_cmd(fsp_pkg::OP_STOP); push_ticks(2);
            wait_idle();
         end
         set_regs(rates[k % 6], steps[k], 25'(lens[k]));
         if (k == 0) push_cmd(fsp_pkg::OP_PLAY);
         repeat (30) cmd_queue.insert(cmd_queue.size(), random_cmd(lens[k]));
         wait_idle();
      end
      // extra phase with a random rate and step
      set_regs(25'($signed($urandom_range(0, 400000)) - 200000),
               25'($urandom_range(1, 8000000)), 25'(DATA_SPAN));
      push_cmd(fsp_pkg::OP_PLAY);
      repeat (40) cmd_queue.insert(cmd_queue.size(), random_cmd(DATA_SPAN));
      wait_idle();

      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule
